// ===== hdl/keypad_code_lock_assert.svh =====
`ifndef KEYPAD_CODE_LOCK_ASSERT_SVH
`define KEYPAD_CODE_LOCK_ASSERT_SVH

`ifndef SYNTHESIS

`define KCL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define KCL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define KCL_ASSERT_IMP(label, clk, rst, ante, cons, msg)

`define KCL_ASSERT_NXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hdl/kcl_pkg.sv =====
`default_nettype none

package kcl_pkg;

   localparam int CODE_LENGTH_DEF = 4;
   localparam int CODE_DIGITS     = 4;
   localparam int SHOWN_POS       = 4;

   localparam int DIGIT_W  = 4;
   localparam int KEY_W    = 5;
   localparam int SHOWN_W  = 5;
   localparam int HALF_W   = 16;
   localparam int PHASE_W  = 3;
   localparam int COUNT_W  = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic       OP_KEY  = 1'b0;
   localparam logic       OP_TICK = 1'b1;

   localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 5'd9;
   localparam logic [KEY_W-1:0] KEY_CLEAR     = 5'd16;
   localparam logic [KEY_W-1:0] KEY_ENTER     = 5'd17;

   localparam logic [SHOWN_W-1:0] SHOW_EIGHT = 5'd8;
   localparam logic [SHOWN_W-1:0] SHOW_ZERO  = 5'd0;
   localparam logic [SHOWN_W-1:0] SHOW_BLANK = 5'd18;

   localparam logic [PHASE_W-1:0] FLASH_LAST_PHASE = 3'd5;

   localparam logic [1:0] FILL_NONE   = 2'd0;
   localparam logic [1:0] FILL_EIGHTS = 2'd1;
   localparam logic [1:0] FILL_ZEROS  = 2'd2;

   localparam logic [1:0] VERDICT_NONE   = 2'd0;
   localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
   localparam logic [1:0] VERDICT_REJECT = 2'd2;

   localparam logic KIND_ACCEPT = 1'b0;
   localparam logic KIND_REJECT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_CODE_DIGIT_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_DIGIT_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_DIGIT_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CODE_DIGIT_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEPT_HALF  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_REJECT_HALF  = 3'd5;

   localparam logic [HALF_W-1:0] ACCEPT_HALF_RST = 16'd250;
   localparam logic [HALF_W-1:0] REJECT_HALF_RST = 16'd150;

   typedef logic [DIGIT_W-1:0] digit_type;

endpackage

`default_nettype wire

// ===== hdl/kcl_if.sv =====
`default_nettype none

interface kcl_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [kcl_pkg::KEY_W-1:0]     key_code;

   modport source (output valid, output op, output key_code, input ready);
   modport sink   (input valid, input op, input key_code, output ready);
endinterface

interface kcl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [kcl_pkg::COUNT_W-1:0]   entered_count;
   logic [kcl_pkg::SHOWN_W-1:0]   shown_0;
   logic [kcl_pkg::SHOWN_W-1:0]   shown_1;
   logic [kcl_pkg::SHOWN_W-1:0]   shown_2;
   logic [kcl_pkg::SHOWN_W-1:0]   shown_3;
   logic [1:0]                    fill_pattern;
   logic                          busy_res;
   logic [1:0]                    verdict;

   modport source (output valid, output entered_count, output shown_0, output shown_1,
                   output shown_2, output shown_3, output fill_pattern, output busy_res,
                   output verdict, input ready);
   modport sink   (input valid, input entered_count, input shown_0, input shown_1,
                   input shown_2, input shown_3, input fill_pattern, input busy_res,
                   input verdict, output ready);
endinterface

`default_nettype wire

// ===== hdl/keypad_code_lock.sv =====
// Keypad code lock.
// req_if carries one transaction per key event (op 0, key_code) or time tick (op 1).
// rsp_if returns exactly one transaction per request: digit count, four display
// codes, fill pattern, busy flag, one-transaction verdict pulse on full-code Enter.
// csr_we/csr_index/csr_wdata write the four code digits and the two flash
// half-periods (in ticks); write only while no request is in flight.
// Latency: the response is registered and appears the cycle after the request
// is taken. Throughput: one transaction per cycle; the lock state is updated in
// the same cycle the request is taken, so requests may follow back to back.
// req_if.ready is high whenever the response register is empty or being drained,
// so a stalled receiver holds the response and blocks new requests only while
// the response register is full.
// Reset (synchronous, active high) empties the entry, stops any flash, drops
// the response valid and restores code 1-2-3-4 and half-periods 250 and 150.
`default_nettype none

`include "keypad_code_lock_assert.svh"

module keypad_code_lock #(
   parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   kcl_req_if.sink                               req_if,
   kcl_rsp_if.source                             rsp_if,
   input  wire logic                             csr_we,
   input  wire logic [kcl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [kcl_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CNT_W = $clog2(CODE_LENGTH + 1);
   localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

   kcl_pkg::digit_type                  code_digit_ff [kcl_pkg::CODE_DIGITS];
   logic [kcl_pkg::HALF_W-1:0]          accept_half_ff;
   logic [kcl_pkg::HALF_W-1:0]          reject_half_ff;

   kcl_pkg::digit_type                  entry_digits_ff [CODE_LENGTH];
   logic [CNT_W-1:0]                    entry_count_ff, entry_count_in;
   logic                                flash_active_ff, flash_active_in;
   logic                                flash_kind_ff, flash_kind_in;
   logic [kcl_pkg::PHASE_W-1:0]         flash_phase_ff, flash_phase_in;
   logic [kcl_pkg::HALF_W-1:0]          phase_ticks_ff, phase_ticks_in;

   logic                                rsp_valid_ff;
   logic [kcl_pkg::COUNT_W-1:0]         rsp_count_ff;
   logic [kcl_pkg::SHOWN_W-1:0]         rsp_shown_ff [kcl_pkg::SHOWN_POS];
   logic [1:0]                          rsp_fill_ff;
   logic                                rsp_busy_ff;
   logic [1:0]                          rsp_verdict_ff;

   logic                                req_fire;
   logic                                digit_we;
   logic [1:0]                          verdict;
   logic [1:0]                          fill;
   logic [kcl_pkg::HALF_W-1:0]          half;
   logic [CODE_LENGTH-1:0]              pos_match;
   logic                                code_ok;
   kcl_pkg::digit_type                  digit_next [CODE_LENGTH];
   logic [kcl_pkg::SHOWN_W-1:0]         shown [kcl_pkg::SHOWN_POS];

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_fire     = req_if.valid && req_if.ready;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         code_digit_ff[0] <= 4'd1;
         code_digit_ff[1] <= 4'd2;
         code_digit_ff[2] <= 4'd3;
         code_digit_ff[3] <= 4'd4;
         accept_half_ff   <= kcl_pkg::ACCEPT_HALF_RST;
         reject_half_ff   <= kcl_pkg::REJECT_HALF_RST;
      end else if (csr_we) begin
         if (csr_index <= kcl_pkg::REG_CODE_DIGIT_3) begin
            code_digit_ff[csr_index[1:0]] <= csr_wdata[kcl_pkg::DIGIT_W-1:0];
         end else if (csr_index == kcl_pkg::REG_ACCEPT_HALF) begin
            accept_half_ff <= csr_wdata;
         end else if (csr_index == kcl_pkg::REG_REJECT_HALF) begin
            reject_half_ff <= csr_wdata;
         end
      end
   end

   // code compare, positions past the configured digits expect zero
   for (genvar gi = 0; gi < CODE_LENGTH; gi++) begin : g_match
      if (gi < kcl_pkg::CODE_DIGITS) begin : g_cfg
         assign pos_match[gi] = (entry_digits_ff[gi] == code_digit_ff[gi]);
      end else begin : g_zero
         assign pos_match[gi] = (entry_digits_ff[gi] == '0);
      end
      assign digit_next[gi] = (digit_we && entry_count_ff[IDX_W-1:0] == IDX_W'(gi)) ?
                              req_if.key_code[kcl_pkg::DIGIT_W-1:0] : entry_digits_ff[gi];
   end
   assign code_ok = &pos_match;

   always_comb begin
      entry_count_in  = entry_count_ff;
      flash_active_in = flash_active_ff;
      flash_kind_in   = flash_kind_ff;
      flash_phase_in  = flash_phase_ff;
      phase_ticks_in  = phase_ticks_ff;
      digit_we        = 1'b0;
      verdict         = kcl_pkg::VERDICT_NONE;
      half            = (flash_kind_ff == kcl_pkg::KIND_ACCEPT) ? accept_half_ff : reject_half_ff;
      if (half == '0) begin
         half = kcl_pkg::HALF_W'(1);
      end
      if (req_fire) begin
         if (req_if.op == kcl_pkg::OP_TICK) begin
            if (flash_active_ff) begin
               if ({1'b0, phase_ticks_ff} + 17'd1 >= {1'b0, half}) begin
                  phase_ticks_in = '0;
                  if (flash_phase_ff == kcl_pkg::FLASH_LAST_PHASE) begin
                     flash_active_in = 1'b0;
                     flash_phase_in  = '0;
                  end else begin
                     flash_phase_in = flash_phase_ff + 3'd1;
                  end
               end else begin
                  phase_ticks_in = phase_ticks_ff + 16'd1;
               end
            end
         end else if (!flash_active_ff) begin
            if (req_if.key_code <= kcl_pkg::KEY_DIGIT_MAX) begin
               if (entry_count_ff < CNT_W'(CODE_LENGTH)) begin
                  digit_we       = 1'b1;
                  entry_count_in = entry_count_ff + CNT_W'(1);
               end
            end else if (req_if.key_code == kcl_pkg::KEY_CLEAR) begin
               entry_count_in = '0;
            end else if (req_if.key_code == kcl_pkg::KEY_ENTER) begin
               if (entry_count_ff == CNT_W'(CODE_LENGTH)) begin
                  flash_active_in = 1'b1;
                  flash_kind_in   = code_ok ? kcl_pkg::KIND_ACCEPT : kcl_pkg::KIND_REJECT;
                  flash_phase_in  = '0;
                  phase_ticks_in  = '0;
                  verdict = code_ok ? kcl_pkg::VERDICT_ACCEPT : kcl_pkg::VERDICT_REJECT;
               end
               entry_count_in = '0;
            end
         end
      end
   end

   always_comb begin
      fill = kcl_pkg::FILL_NONE;
      if (flash_active_in && !flash_phase_in[0]) begin
         fill = (flash_kind_in == kcl_pkg::KIND_ACCEPT) ? kcl_pkg::FILL_EIGHTS :
                                                         kcl_pkg::FILL_ZEROS;
      end
   end

   for (genvar gp = 0; gp < kcl_pkg::SHOWN_POS; gp++) begin : g_show
      if (gp < CODE_LENGTH) begin : g_digit
         always_comb begin
            if (flash_active_in) begin
               shown[gp] = (fill == kcl_pkg::FILL_EIGHTS) ? kcl_pkg::SHOW_EIGHT :
                           (fill == kcl_pkg::FILL_ZEROS)  ? kcl_pkg::SHOW_ZERO  :
                                                            kcl_pkg::SHOW_BLANK;
            end else if (gp < int'(entry_count_in)) begin
               shown[gp] = {1'b0, digit_next[gp]};
            end else begin
               shown[gp] = kcl_pkg::SHOW_BLANK;
            end
         end
      end else begin : g_none
         always_comb begin
            if (flash_active_in) begin
               shown[gp] = (fill == kcl_pkg::FILL_EIGHTS) ? kcl_pkg::SHOW_EIGHT :
                           (fill == kcl_pkg::FILL_ZEROS)  ? kcl_pkg::SHOW_ZERO  :
                                                            kcl_pkg::SHOW_BLANK;
            end else begin
               shown[gp] = kcl_pkg::SHOW_BLANK;
            end
         end
      end
   end

   // lock state
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff  <= '0;
         flash_active_ff <= 1'b0;
         flash_kind_ff   <= kcl_pkg::KIND_ACCEPT;
         flash_phase_ff  <= '0;
         phase_ticks_ff  <= '0;
      end else begin
         entry_count_ff  <= entry_count_in;
         flash_active_ff <= flash_active_in;
         flash_kind_ff   <= flash_kind_in;
         flash_phase_ff  <= flash_phase_in;
         phase_ticks_ff  <= phase_ticks_in;
      end
   end

   always_ff @(posedge clock) begin
      if (digit_we) begin
         entry_digits_ff[entry_count_ff[IDX_W-1:0]] <= req_if.key_code[kcl_pkg::DIGIT_W-1:0];
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_count_ff   <= kcl_pkg::COUNT_W'(entry_count_in);
         rsp_shown_ff   <= shown;
         rsp_fill_ff    <= fill;
         rsp_busy_ff    <= flash_active_in;
         rsp_verdict_ff <= verdict;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.entered_count = rsp_count_ff;
   assign rsp_if.shown_0       = rsp_shown_ff[0];
   assign rsp_if.shown_1       = rsp_shown_ff[1];
   assign rsp_if.shown_2       = rsp_shown_ff[2];
   assign rsp_if.shown_3       = rsp_shown_ff[3];
   assign rsp_if.fill_pattern  = rsp_fill_ff;
   assign rsp_if.busy_res      = rsp_busy_ff;
   assign rsp_if.verdict       = rsp_verdict_ff;

   `KCL_ASSERT_IMP(a_phase_idle, clock, reset, !flash_active_ff,
                   flash_phase_ff == '0 && phase_ticks_ff == '0,
                   "flash counters not clear while idle")
   `KCL_ASSERT_IMP(a_count_range, clock, reset, 1'b1,
                   entry_count_ff <= CNT_W'(CODE_LENGTH),
                   "entry count beyond code length")
   `KCL_ASSERT_NXT(a_key_blocked, clock, reset,
                   req_fire && req_if.op == kcl_pkg::OP_KEY && flash_active_ff,
                   $stable(entry_count_ff) && flash_active_ff,
                   "key changed lock during flash")
   `KCL_ASSERT_IMP(a_verdict_busy, clock, reset,
                   rsp_valid_ff && rsp_verdict_ff != kcl_pkg::VERDICT_NONE,
                   rsp_busy_ff && rsp_count_ff == '0,
                   "verdict without flash start")

endmodule

`default_nettype wire
